// ===== rtl/pip_pkg.sv =====
// Shared types, constants and rounding helper for the PID block.
`timescale 1ns / 1ps

package pip_pkg;

    localparam int ERR_W  = 26;
    localparam int ACC_W  = 58;
    localparam int DRV_W  = 40;
    localparam int IDX_W  = 3;

    // Q.16 weights for older (0.92) and newest (1.08) errors
    localparam logic signed [17:0] W_OLD_Q16 = 18'sd60293;
    localparam logic signed [17:0] W_NEW_Q16 = 18'sd70779;

    localparam logic signed [DRV_W-1:0] DRIVE_MAX = {1'b0, {(DRV_W-1){1'b1}}};
    localparam logic signed [DRV_W-1:0] DRIVE_MIN = {1'b1, {(DRV_W-1){1'b0}}};

    typedef enum logic [IDX_W-1:0] {
        REG_MODE         = 3'd0,
        REG_GAIN_P       = 3'd1,
        REG_GAIN_I       = 3'd2,
        REG_GAIN_D       = 3'd3,
        REG_INTEGRAL_MAX = 3'd4,
        REG_INTEGRAL_MIN = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic signed [31:0] integral_max;
        logic signed [31:0] integral_min;
    } cfg_t;

    typedef struct packed {
        logic                    valid;
        logic signed [15:0]      err;
        logic signed [ERR_W-1:0] err_w;
    } s1_t;

    // Round a Q.24 product to Q.8, nearest, ties toward plus infinity
    function automatic logic signed [ERR_W-1:0] round_q16(input logic signed [43:0] x);
        logic signed [43:0] sum;
        begin
            sum = x + 44'sd32768;
            return sum[ERR_W+15:16];
        end
    endfunction

endpackage

// ===== rtl/pid_positional_incremental.sv =====
// Top level of the positional / incremental PID controller.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid / in_stall  | error_sample (16 bit signed)
//  out     | output    | out_valid / out_stall| drive (40 bit signed), saturated
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index (3 bit), cfg_data (32 bit)
//
// One item per cycle sustained while out_stall is low. The input transfer loads the
// input register; the item then moves on from there into the result register.
// The error state and integral update in the same cycle the item reaches the
// result register, so consecutive items chain with no gap.
// Reset clears the error state, integral and gains and opens the integral limits.
// A stalled result holds; the input register still takes one more item behind it.
`timescale 1ns / 1ps

module pid_positional_incremental
    import pip_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [15:0]       error_sample,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DRV_W-1:0]  drive,
    output logic                     saturated,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [31:0]              cfg_data
);

    cfg_t cfg;
    s1_t  s1;
    logic advance;

    pip_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pip_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .error_sample (error_sample),
        .advance      (advance),
        .s1           (s1)
    );

    pip_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s1        (s1),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive),
        .saturated (saturated)
    );

    // An item leaving the input register always shows up as a result
    a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1.valid && advance) |=> out_valid)
        else $error("item dropped between input and result register");

    // A clipped drive sits on one of the range ends
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (drive == DRIVE_MAX || drive == DRIVE_MIN))
        else $error("saturated flag set on an in-range drive");

    // With no result pending the input side never stalls
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while result register is empty");

endmodule

// ===== rtl/pip_cfg_regs.sv =====
// Configuration register file for the PID block.
`timescale 1ns / 1ps

module pip_cfg_regs
    import pip_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [31:0]      cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MODE:         cfg_next.mode         = cfg_data[0];
                REG_GAIN_P:       cfg_next.gain_p       = cfg_data[15:0];
                REG_GAIN_I:       cfg_next.gain_i       = cfg_data[15:0];
                REG_GAIN_D:       cfg_next.gain_d       = cfg_data[15:0];
                REG_INTEGRAL_MAX: cfg_next.integral_max = cfg_data;
                REG_INTEGRAL_MIN: cfg_next.integral_min = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= 1'b0;
            cfg_reg.gain_p       <= '0;
            cfg_reg.gain_i       <= '0;
            cfg_reg.gain_d       <= '0;
            cfg_reg.integral_max <= 32'sh7fff_ffff;
            cfg_reg.integral_min <= 32'sh8000_0000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/pip_in_stage.sv =====
// Input register: holds the accepted sample and its 1.08-weighted Q.8 form.
`timescale 1ns / 1ps

module pip_in_stage
    import pip_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] error_sample,
    input  logic               advance,
    output s1_t                s1
);

    logic                    valid_reg;
    logic                    valid_next;
    logic signed [15:0]      err_reg;
    logic signed [ERR_W-1:0] err_w_reg;
    logic signed [23:0]      err_q8;
    logic signed [43:0]      prod_new;
    logic                    accept;

    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign err_q8   = {error_sample, 8'd0};
    assign prod_new = 44'(err_q8) * 44'(W_NEW_Q16);

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg   <= error_sample;
            err_w_reg <= round_q16(prod_new);
        end
    end

    assign s1.valid = valid_reg;
    assign s1.err   = err_reg;
    assign s1.err_w = err_w_reg;

endmodule

// ===== rtl/pip_core.sv =====
// Error state, integral, gain products, rounding, saturation and result register.
`timescale 1ns / 1ps

module pip_core
    import pip_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  s1_t                      s1,
    output logic                     advance,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DRV_W-1:0]  drive,
    output logic                     saturated
);

    // State: last error, 0.92-weighted copies of current and last error, integral
    logic signed [ERR_W-1:0] err_last_reg,  err_last_next;
    logic signed [ERR_W-1:0] now_w_reg,     now_w_next;
    logic signed [ERR_W-1:0] last_w_reg,    last_w_next;
    logic signed [31:0]      integral_reg,  integral_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [DRV_W-1:0] drive_reg,     drive_next;
    logic                    sat_reg,       sat_next;

    logic                    take;
    logic signed [23:0]      e_q8;
    logic signed [32:0]      int_sum;
    logic signed [32:0]      int_hi;
    logic signed [32:0]      int_clamp;
    logic signed [ERR_W-1:0] en;
    logic signed [26:0]      op_p;
    logic signed [32:0]      op_i;
    logic signed [27:0]      op_d;
    logic signed [42:0]      prod_p;
    logic signed [48:0]      prod_i;
    logic signed [43:0]      prod_d;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [49:0]      drv_full;
    logic                    drv_fits;
    logic signed [ERR_W-1:0] w_src;
    logic signed [43:0]      prod_now_w;
    logic signed [43:0]      prod_last_w;

    assign advance = !out_valid_reg || !out_stall;
    assign take    = s1.valid && advance;

    assign e_q8 = {s1.err, 8'd0};
    assign en   = s1.err_w;

    // Integral: add, limit to max, then raise to min
    assign int_sum   = 33'(integral_reg) + 33'(s1.err);
    assign int_hi    = (int_sum > 33'(cfg.integral_max)) ? 33'(cfg.integral_max) : int_sum;
    assign int_clamp = (int_hi < 33'(cfg.integral_min)) ? 33'(cfg.integral_min) : int_hi;

    always_comb
    begin
        if (cfg.mode)
        begin
            op_p = 27'(en) - 27'(now_w_reg);
            op_i = 33'(en);
            op_d = 28'(en) - (28'(now_w_reg) <<< 1) + 28'(last_w_reg);
        end
        else
        begin
            op_p = 27'(e_q8);
            op_i = int_clamp;
            op_d = 28'(e_q8) - 28'(err_last_reg);
        end
    end

    assign prod_p = 43'(op_p) * 43'(cfg.gain_p);
    assign prod_i = 49'(op_i) * 49'(cfg.gain_i);
    assign prod_d = 44'(op_d) * 44'(cfg.gain_d);

    // Integral term carries integer units in positional mode: scale to Q.8
    assign acc = 58'(prod_p) + 58'(prod_d)
               + (cfg.mode ? 58'(prod_i) : (58'(prod_i) <<< 8));

    assign acc_rnd  = acc + 58'sd128;
    assign drv_full = acc_rnd[ACC_W-1:8];
    assign drv_fits = (&drv_full[49:DRV_W-1]) || !(|drv_full[49:DRV_W-1]);

    always_comb
    begin
        if (drv_fits)
            drive_next = drv_full[DRV_W-1:0];
        else if (drv_full[49])
            drive_next = DRIVE_MIN;
        else
            drive_next = DRIVE_MAX;
        sat_next = !drv_fits;
    end

    // Weighted copies of the state are ready before the next item arrives
    assign w_src       = cfg.mode ? en : ERR_W'(e_q8);
    assign prod_now_w  = 44'(w_src) * 44'(W_OLD_Q16);
    assign prod_last_w = 44'(now_w_reg) * 44'(W_OLD_Q16);

    always_comb
    begin
        err_last_next = err_last_reg;
        now_w_next    = now_w_reg;
        last_w_next   = last_w_reg;
        integral_next = integral_reg;
        if (take)
        begin
            now_w_next = round_q16(prod_now_w);
            if (cfg.mode)
            begin
                err_last_next = now_w_reg;
                last_w_next   = round_q16(prod_last_w);
            end
            else
            begin
                err_last_next = ERR_W'(e_q8);
                last_w_next   = round_q16(prod_now_w);
                integral_next = int_clamp[31:0];
            end
        end
    end

    always_comb
    begin
        if (take)
            out_valid_next = 1'b1;
        else if (advance)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_last_reg  <= '0;
            now_w_reg     <= '0;
            last_w_reg    <= '0;
            integral_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            err_last_reg  <= err_last_next;
            now_w_reg     <= now_w_next;
            last_w_reg    <= last_w_next;
            integral_reg  <= integral_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            drive_reg <= drive_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign saturated = sat_reg;

endmodule
